// ===== src/ble_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the list engine.
`timescale 1ns / 1ps

package ble_pkg;

   localparam int CAPACITY = 16;
   localparam int SLOT_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int OP_W     = 3;
   localparam int POS_W    = 4;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef enum logic [OP_W-1:0] {
      OP_ADD_FRONT = 3'd0,
      OP_ADD_END   = 3'd1,
      OP_REM_FRONT = 3'd2,
      OP_REM_END   = 3'd3,
      OP_READ      = 3'd4,
      OP_INSERT    = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_RANGE = 2'd2,
      STAT_FULL  = 2'd3
   } status_type;

   // datapath micro-operations, one per cycle
   typedef enum logic [3:0] {
      UOP_NONE,
      UOP_LATCH,
      UOP_RESULT,
      UOP_TAKE_FRESH,
      UOP_TAKE_FREE,
      UOP_POP,
      UOP_ADD_FRONT,
      UOP_ADD_END,
      UOP_SETUP,
      UOP_STEP,
      UOP_READ_CAP,
      UOP_RF_CAP,
      UOP_RE_CAP,
      UOP_RE_FIN,
      UOP_INS_W1,
      UOP_INS_W2
   } uop_type;

   // shared read address of both slot memories
   typedef enum logic [2:0] {
      RD_P,
      RD_FRONT,
      RD_BACK,
      RD_FHEAD,
      RD_LINK
   } rd_sel_type;

   typedef struct packed {
      uop_type    uop;
      rd_sel_type rd_sel;
      status_type status;
      logic       load_out;
   } ble_cmd_type;

   typedef struct packed {
      op_type op;
      logic   empty;
      logic   full;
      logic   pos_ok;
      logic   cnt_gt1;
      logic   free_avail;
      logic   steps_zero;
   } ble_sts_type;

endpackage

// ===== src/ble_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ble_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/ble_dp.sv =====
// Datapath: slot memories, list pointers, free chain, walk pointer and result registers.
`timescale 1ns / 1ps

module ble_dp
   import ble_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  ble_cmd_type                cmd,
   output ble_sts_type                sts,
   input  logic [OP_W-1:0]            req_opcode,
   input  logic [POS_W-1:0]           req_position,
   input  logic signed [DATA_W-1:0]   req_data_in,
   output logic signed [DATA_W-1:0]   rsp_data_out,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [COUNT_W-1:0]         rsp_element_count,
   output logic                       rsp_list_empty
);

   // list and free chain
   logic [SLOT_W-1:0] front_ff, front_in;
   logic [SLOT_W-1:0] back_ff, back_in;
   logic [SLOT_W-1:0] fhead_ff, fhead_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   // slots below fresh_ff have been used at least once; fresh - count are on the free chain
   logic [CNT_W-1:0]  fresh_ff, fresh_in;

   // working registers
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W-1:0] p_ff, p_in;
   logic [CNT_W-1:0]  steps_ff, steps_in;
   op_type            op_ff, op_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic signed [DATA_W-1:0] din_ff, din_in;
   status_type        res_status_ff, res_status_in;
   logic signed [DATA_W-1:0] res_data_ff, res_data_in;

   // output beat registers
   logic signed [DATA_W-1:0] out_data_ff;
   status_type               out_status_ff;
   logic [COUNT_W-1:0]       out_count_ff;
   logic                     out_empty_ff;

   // memory ports
   logic [SLOT_W-1:0] rd_addr;
   logic              val_we;
   logic [DATA_W-1:0] val_rdata;
   logic              link_we;
   logic [SLOT_W-1:0] link_waddr;
   logic [SLOT_W-1:0] link_wdata;
   logic [SLOT_W-1:0] link_rdata;

   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   ble_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_values (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (slot_ff),
      .wr_data (din_ff),
      .rd_addr (rd_addr),
      .rd_data (val_rdata)
   );

   ble_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_links (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (rd_addr),
      .rd_data (link_rdata)
   );

   always_comb begin
      case (cmd.rd_sel)
         RD_FRONT: rd_addr = front_ff;
         RD_BACK:  rd_addr = back_ff;
         RD_FHEAD: rd_addr = fhead_ff;
         RD_LINK:  rd_addr = link_rdata;
         default:  rd_addr = p_ff;
      endcase
   end

   assign sts.op         = op_ff;
   assign sts.empty      = (count_ff == '0);
   assign sts.full       = (count_ff == CNT_W'(CAPACITY));
   assign sts.pos_ok     = (CMP_W'(pos_ff) < CMP_W'(count_ff));
   assign sts.cnt_gt1    = (count_ff > CNT_W'(1));
   assign sts.free_avail = (fresh_ff > count_ff);
   assign sts.steps_zero = (steps_ff == '0);

   always_comb begin
      front_in      = front_ff;
      back_in       = back_ff;
      fhead_in      = fhead_ff;
      count_in      = count_ff;
      fresh_in      = fresh_ff;
      slot_in       = slot_ff;
      p_in          = p_ff;
      steps_in      = steps_ff;
      op_in         = op_ff;
      pos_in        = pos_ff;
      din_in        = din_ff;
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      val_we        = 1'b0;
      link_we       = 1'b0;
      link_waddr    = slot_ff;
      link_wdata    = front_ff;
      case (cmd.uop)
         UOP_LATCH: begin
            op_in  = op_type'(req_opcode);
            pos_in = req_position;
            din_in = req_data_in;
         end
         UOP_RESULT: begin
            res_status_in = cmd.status;
            res_data_in   = '0;
         end
         UOP_TAKE_FRESH: begin
            slot_in  = fresh_ff[SLOT_W-1:0];
            fresh_in = fresh_ff + CNT_W'(1);
         end
         UOP_TAKE_FREE: begin
            slot_in = fhead_ff;
         end
         UOP_POP: begin
            fhead_in = link_rdata;
         end
         UOP_ADD_FRONT: begin
            val_we     = 1'b1;
            link_we    = 1'b1;
            link_waddr = slot_ff;
            link_wdata = front_ff;
            front_in   = slot_ff;
            if (count_ff == '0) begin
               back_in = slot_ff;
            end
            count_in = count_ff + CNT_W'(1);
         end
         UOP_ADD_END: begin
            val_we = 1'b1;
            if (count_ff != '0) begin
               link_we    = 1'b1;
               link_waddr = back_ff;
               link_wdata = slot_ff;
            end else begin
               front_in = slot_ff;
            end
            back_in  = slot_ff;
            count_in = count_ff + CNT_W'(1);
         end
         UOP_SETUP: begin
            p_in = front_ff;
            if (op_ff == OP_REM_END) begin
               steps_in = count_ff - CNT_W'(2);
            end else begin
               steps_in = CNT_W'(pos_ff);
            end
         end
         UOP_STEP: begin
            p_in     = link_rdata;
            steps_in = steps_ff - CNT_W'(1);
         end
         UOP_READ_CAP: begin
            res_data_in = val_rdata;
         end
         UOP_RF_CAP: begin
            res_data_in = val_rdata;
            front_in    = link_rdata;
            link_we     = 1'b1;
            link_waddr  = front_ff;
            link_wdata  = fhead_ff;
            fhead_in    = front_ff;
            count_in    = count_ff - CNT_W'(1);
         end
         UOP_RE_CAP: begin
            res_data_in = val_rdata;
            link_we     = 1'b1;
            link_waddr  = back_ff;
            link_wdata  = fhead_ff;
            fhead_in    = back_ff;
         end
         UOP_RE_FIN: begin
            // p holds the predecessor; meaningless when the list just went empty
            back_in  = p_ff;
            count_in = count_ff - CNT_W'(1);
         end
         UOP_INS_W1: begin
            val_we     = 1'b1;
            link_we    = 1'b1;
            link_waddr = slot_ff;
            link_wdata = link_rdata;
         end
         UOP_INS_W2: begin
            link_we    = 1'b1;
            link_waddr = p_ff;
            link_wdata = slot_ff;
            if (p_ff == back_ff) begin
               back_in = slot_ff;
            end
            count_in = count_ff + CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fresh_ff <= '0;
      end else begin
         count_ff <= count_in;
         fresh_ff <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff      <= front_in;
      back_ff       <= back_in;
      fhead_ff      <= fhead_in;
      slot_ff       <= slot_in;
      p_ff          <= p_in;
      steps_ff      <= steps_in;
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      din_ff        <= din_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      if (cmd.load_out) begin
         out_data_ff   <= res_data_ff;
         out_status_ff <= res_status_ff;
         out_count_ff  <= COUNT_W'(count_ff);
         out_empty_ff  <= (count_ff == '0);
      end
   end

   assign rsp_data_out      = out_data_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_element_count = out_count_ff;
   assign rsp_list_empty    = out_empty_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   a_fresh_order: assert property (@(posedge clock) disable iff (reset)
      (fresh_ff >= count_ff) && (fresh_ff <= CNT_W'(CAPACITY)))
      else $error("fresh slot mark inconsistent with count");

   a_fresh_take: assert property (@(posedge clock) disable iff (reset)
      (cmd.uop == UOP_TAKE_FRESH) |-> (fresh_ff < CNT_W'(CAPACITY)))
      else $error("fresh slot taken past capacity");
`endif

endmodule

// ===== src/ble_ctrl.sv =====
// Controller: sequences each operation into datapath micro-operations and owns the handshakes.
`timescale 1ns / 1ps

module ble_ctrl
   import ble_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ble_cmd_type cmd,
   input  ble_sts_type sts
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_ALLOC,
      S_POP,
      S_AF_WR,
      S_AE_WR,
      S_SETUP,
      S_WALK,
      S_RD_POST,
      S_INS_W1,
      S_INS_W2,
      S_RF_RD,
      S_RF_CAP,
      S_RE_RD,
      S_RE_CAP,
      S_RE_FIN,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   state_type after_alloc;
   state_type after_walk;

   always_comb begin
      case (sts.op)
         OP_ADD_FRONT: after_alloc = S_AF_WR;
         OP_ADD_END:   after_alloc = S_AE_WR;
         default:      after_alloc = S_SETUP;
      endcase
      case (sts.op)
         OP_READ:   after_walk = S_RD_POST;
         OP_INSERT: after_walk = S_INS_W1;
         default:   after_walk = S_RE_FIN;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cmd.uop      = UOP_NONE;
      cmd.rd_sel   = RD_P;
      cmd.status   = STAT_OK;
      cmd.load_out = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.uop  = UOP_LATCH;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.uop  = UOP_RESULT;
            state_in = S_FINISH;
            case (sts.op)
               OP_ADD_FRONT, OP_ADD_END: begin
                  if (sts.full) begin
                     cmd.status = STAT_FULL;
                  end else begin
                     state_in = S_ALLOC;
                  end
               end
               OP_REM_FRONT: begin
                  if (sts.empty) begin
                     cmd.status = STAT_EMPTY;
                  end else begin
                     state_in = S_RF_RD;
                  end
               end
               OP_REM_END: begin
                  if (sts.empty) begin
                     cmd.status = STAT_EMPTY;
                  end else begin
                     state_in = S_RE_RD;
                  end
               end
               OP_READ: begin
                  if (!sts.pos_ok) begin
                     cmd.status = STAT_RANGE;
                  end else begin
                     state_in = S_SETUP;
                  end
               end
               OP_INSERT: begin
                  // range check takes precedence over full
                  if (!sts.pos_ok) begin
                     cmd.status = STAT_RANGE;
                  end else if (sts.full) begin
                     cmd.status = STAT_FULL;
                  end else begin
                     state_in = S_ALLOC;
                  end
               end
               default: begin
               end
            endcase
         end
         S_ALLOC: begin
            if (sts.free_avail) begin
               cmd.uop    = UOP_TAKE_FREE;
               cmd.rd_sel = RD_FHEAD;
               state_in   = S_POP;
            end else begin
               cmd.uop  = UOP_TAKE_FRESH;
               state_in = after_alloc;
            end
         end
         S_POP: begin
            cmd.uop  = UOP_POP;
            state_in = after_alloc;
         end
         S_AF_WR: begin
            cmd.uop  = UOP_ADD_FRONT;
            state_in = S_FINISH;
         end
         S_AE_WR: begin
            cmd.uop  = UOP_ADD_END;
            state_in = S_FINISH;
         end
         S_SETUP: begin
            cmd.uop    = UOP_SETUP;
            cmd.rd_sel = RD_FRONT;
            state_in   = S_WALK;
         end
         S_WALK: begin
            // one link per cycle; on exit re-read at p so value and link of p are ready
            if (sts.steps_zero) begin
               cmd.rd_sel = RD_P;
               state_in   = after_walk;
            end else begin
               cmd.uop    = UOP_STEP;
               cmd.rd_sel = RD_LINK;
            end
         end
         S_RD_POST: begin
            cmd.uop  = UOP_READ_CAP;
            state_in = S_FINISH;
         end
         S_INS_W1: begin
            cmd.uop  = UOP_INS_W1;
            state_in = S_INS_W2;
         end
         S_INS_W2: begin
            cmd.uop  = UOP_INS_W2;
            state_in = S_FINISH;
         end
         S_RF_RD: begin
            cmd.rd_sel = RD_FRONT;
            state_in   = S_RF_CAP;
         end
         S_RF_CAP: begin
            cmd.uop  = UOP_RF_CAP;
            state_in = S_FINISH;
         end
         S_RE_RD: begin
            cmd.rd_sel = RD_BACK;
            state_in   = S_RE_CAP;
         end
         S_RE_CAP: begin
            cmd.uop  = UOP_RE_CAP;
            state_in = sts.cnt_gt1 ? S_SETUP : S_RE_FIN;
         end
         S_RE_FIN: begin
            cmd.uop  = UOP_RE_FIN;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DECODE))
      else $error("accepted beat not decoded");

   a_alloc_not_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ALLOC) |-> !sts.full)
      else $error("slot allocation on a full list");

   a_walk_continues: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && !sts.steps_zero) |=> (state_ff == S_WALK))
      else $error("walk left before reaching its target");
`endif

endmodule

// ===== src/bounded_list_engine.sv =====
// Top level of the bounded list engine: controller plus datapath.
//
// Ordered list of up to CAPACITY signed 32-bit values kept as a linked chain in
// two slot RAMs (values and next links). One request beat gives exactly one
// response beat. Requests are handled one at a time; a new request is taken
// while the previous response still waits on rsp_ready. Adds at either end,
// removal at the front and error responses need no walk; read and insert at
// position k walk k links down the chain, and remove end on a list of n
// elements walks n-2 links (none when n is 1). The
// walk down the chain sets the long cases: one read of the link RAM per
// element passed. Slots freed by removals are recycled through a free chain
// threaded through the link RAM, so no clearing pass is needed after reset.
`timescale 1ns / 1ps

module bounded_list_engine
   import ble_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [OP_W-1:0]           req_opcode,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [DATA_W-1:0]  req_data_in,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [DATA_W-1:0]  rsp_data_out,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [COUNT_W-1:0]        rsp_element_count,
   output logic                      rsp_list_empty
);

   ble_cmd_type cmd;
   ble_sts_type sts;

   ble_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   ble_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_opcode        (req_opcode),
      .req_position      (req_position),
      .req_data_in       (req_data_in),
      .rsp_data_out      (rsp_data_out),
      .rsp_status        (rsp_status),
      .rsp_element_count (rsp_element_count),
      .rsp_list_empty    (rsp_list_empty)
   );

endmodule

// ===== test/bounded_list_engine_tb.sv =====
// Testbench for the bounded list engine: directed table, then random traffic checked by a queue model.
`timescale 1ns / 1ps

module bounded_list_engine_tb;
   import ble_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
   localparam int RAND_ITEMS  = 1720;
   localparam int HOLD_AT     = 600;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic [STATUS_W-1:0]      status;
      logic [COUNT_W-1:0]       count;
      logic                     empty;
   } rsp_beat_type;

   typedef struct {
      logic [OP_W-1:0]          op;
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] data;
      int                       reps;
      bit                       typed;
      rsp_beat_type             want;
   } dir_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [OP_W-1:0]          req_opcode = '0;
   logic [POS_W-1:0]         req_position = '0;
   logic signed [DATA_W-1:0] req_data_in = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_data_out;
   logic [STATUS_W-1:0]      rsp_status;
   logic [COUNT_W-1:0]       rsp_element_count;
   logic                     rsp_list_empty;

   // typed-in expectation travels with the request beat
   bit           note_typed = 1'b0;
   rsp_beat_type note_want = '0;

   logic signed [DATA_W-1:0] list_model[$];
   rsp_beat_type             expected_rsps[$];
   int                       fails = 0;
   bit                       hold_rsp = 1'b0;
   bit                       sender_no_gaps = 1'b0;

   bounded_list_engine dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_position      (req_position),
      .req_data_in       (req_data_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data_out      (rsp_data_out),
      .rsp_status        (rsp_status),
      .rsp_element_count (rsp_element_count),
      .rsp_list_empty    (rsp_list_empty)
   );

   always #4 clock = ~clock;

   // Applies one operation to the list model and returns the response it gives.
   function automatic rsp_beat_type apply_list_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                                  logic signed [DATA_W-1:0] val);
      rsp_beat_type r;
      int n;
      r = '0;
      r.status = STAT_OK;
      n = list_model.size();
      case (op)
         OP_ADD_FRONT: begin
            if (n >= CAPACITY) r.status = STAT_FULL;
            else list_model.push_front(val);
         end
         OP_ADD_END: begin
            if (n >= CAPACITY) r.status = STAT_FULL;
            else list_model.push_back(val);
         end
         OP_REM_FRONT: begin
            if (n == 0) r.status = STAT_EMPTY;
            else r.data = list_model.pop_front();
         end
         OP_REM_END: begin
            if (n == 0) r.status = STAT_EMPTY;
            else r.data = list_model.pop_back();
         end
         OP_READ: begin
            if (int'(pos) >= n) r.status = STAT_RANGE;
            else r.data = list_model[pos];
         end
         OP_INSERT: begin
            // range check wins over full
            if (int'(pos) >= n) r.status = STAT_RANGE;
            else if (n >= CAPACITY) r.status = STAT_FULL;
            else list_model.insert(int'(pos) + 1, val);
         end
         default: ;
      endcase
      r.count = COUNT_W'(list_model.size());
      r.empty = (list_model.size() == 0);
      return r;
   endfunction

   function automatic dir_row_type dir_row(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                           logic signed [DATA_W-1:0] data, int reps, bit typed,
                                           logic [STATUS_W-1:0] st, logic [COUNT_W-1:0] cnt);
      dir_row_type rw;
      rw.op = op;
      rw.pos = pos;
      rw.data = data;
      rw.reps = reps;
      rw.typed = typed;
      rw.want.data = '0;
      rw.want.status = st;
      rw.want.count = cnt;
      rw.want.empty = (cnt == 0);
      return rw;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 92) return $urandom_range(1, 3);
      else return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      if ($urandom_range(0, 9) != 0) return $urandom;
      case ($urandom_range(0, 3))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return '0;
         default: return '1;
      endcase
   endfunction

   task automatic flag_mismatch(string field, longint want, longint got);
      $error("%s: expected %0d, actual %0d", field, want, got);
      fails++;
   endtask

   task automatic send_req(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                           logic signed [DATA_W-1:0] val, bit typed, rsp_beat_type want);
      int gap;
      req_valid <= 1'b1;
      req_opcode <= op;
      req_position <= pos;
      req_data_in <= val;
      note_typed <= typed;
      note_want <= want;
      do @(posedge clock); while (!req_ready);
      gap = sender_no_gaps ? 0 : idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // response check first: a beat leaving at the same edge belongs to an older request
   always @(posedge clock) begin : scoreboard
      rsp_beat_type got;
      rsp_beat_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got.data = rsp_data_out;
            got.status = rsp_status;
            got.count = rsp_element_count;
            got.empty = rsp_list_empty;
            if (expected_rsps.size() == 0) begin
               $error("response beat with no request pending");
               fails++;
            end else begin
               want = expected_rsps.pop_front();
               if (got.data !== want.data) flag_mismatch("data_out", want.data, got.data);
               if (got.status !== want.status)
                  flag_mismatch("status", want.status, got.status);
               if (got.count !== want.count)
                  flag_mismatch("element_count", want.count, got.count);
               if (got.empty !== want.empty)
                  flag_mismatch("list_empty", want.empty, got.empty);
            end
         end
         if (req_valid && req_ready) begin
            want = apply_list_op(req_opcode, req_position, req_data_in);
            expected_rsps.push_back(note_typed ? note_want : want);
         end
      end
   end

   // response side: ready runs and stalls, plus one long hold-off on request
   initial begin : rsp_side
      int run;
      int gap;
      while (reset) @(posedge clock);
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
         rsp_ready <= 1'b1;
         repeat (run) @(posedge clock);
         if (hold_rsp) begin
            gap = HOLD_CYCLES;
            hold_rsp = 1'b0;
         end else begin
            gap = idle_cycles();
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      dir_row_type              rows[$];
      dir_row_type              rw;
      logic [OP_W-1:0]          op;
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] val;
      int                       n;
      int                       pick;
      int                       phase_left;
      bit                       grow;
      rsp_beat_type             none;
      none = '0;
      phase_left = 0;
      grow = 1'b1;

      // empty-list errors and spare opcodes
      rows.push_back(dir_row(OP_READ,      4'd0,  '0, 1, 1, STAT_RANGE, 5'd0));
      rows.push_back(dir_row(OP_REM_FRONT, 4'd0,  '0, 1, 1, STAT_EMPTY, 5'd0));
      rows.push_back(dir_row(OP_REM_END,   4'd15, '0, 1, 1, STAT_EMPTY, 5'd0));
      rows.push_back(dir_row(OP_INSERT,    4'd0,  '1, 1, 1, STAT_RANGE, 5'd0));
      rows.push_back(dir_row(OP_SPARE_LO,  4'd3,  '1, 1, 1, STAT_OK,    5'd0));
      rows.push_back(dir_row(OP_SPARE_HI,  4'd15, '1, 1, 1, STAT_OK,    5'd0));
      // extremes of the value range
      rows.push_back(dir_row(OP_ADD_FRONT, 4'd0, 32'sh7FFF_FFFF, 1, 1, STAT_OK, 5'd1));
      rows.push_back(dir_row(OP_ADD_END,   4'd0, 32'sh8000_0000, 1, 1, STAT_OK, 5'd2));
      rows.push_back(dir_row(OP_READ,      4'd1, '0, 1, 0, STAT_OK, '0));
      rows.push_back(dir_row(OP_INSERT,    4'd0, '1, 1, 0, STAT_OK, '0));
      // insert after the last element moves the back
      rows.push_back(dir_row(OP_INSERT,    4'd2, '0, 1, 0, STAT_OK, '0));
      rows.push_back(dir_row(OP_REM_END,   4'd0, '0, 1, 0, STAT_OK, '0));
      rows.push_back(dir_row(OP_ADD_END,   4'd0, 32'sh1000_0000, 13, 0, STAT_OK, '0));
      // full list
      rows.push_back(dir_row(OP_ADD_FRONT, 4'd0,  32'sh5555_5555, 1, 1, STAT_FULL, 5'd16));
      rows.push_back(dir_row(OP_ADD_END,   4'd0,  32'shAAAA_AAAA, 1, 1, STAT_FULL, 5'd16));
      rows.push_back(dir_row(OP_INSERT,    4'd15, 32'sh0F0F_0F0F, 1, 1, STAT_FULL, 5'd16));
      rows.push_back(dir_row(OP_READ,      4'd15, '0, 1, 0, STAT_OK, '0));
      rows.push_back(dir_row(OP_REM_END,   4'd0,  '0, 1, 0, STAT_OK, '0));
      rows.push_back(dir_row(OP_READ,      4'd15, '0, 1, 1, STAT_RANGE, 5'd15));
      rows.push_back(dir_row(OP_REM_FRONT, 4'd0,  '0, 1, 0, STAT_OK, '0));
      rows.push_back(dir_row(OP_INSERT,    4'd14, '1, 1, 1, STAT_RANGE, 5'd14));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         rw = rows[i];
         for (int k = 0; k < rw.reps; k++)
            send_req(rw.op, rw.pos, rw.data + k, rw.typed, rw.want);
      end

      // random traffic in grow and shrink phases so the list swings between empty and full
      for (int k = 0; k < RAND_ITEMS; k++) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(40, 160);
            grow = ~grow;
            sender_no_gaps = ($urandom_range(0, 3) == 0);
         end
         phase_left--;
         if (k == HOLD_AT) hold_rsp = 1'b1;
         n = list_model.size();
         pick = $urandom_range(0, 99);
         if (pick < 3) op = ($urandom_range(0, 1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
         else if (pick < (grow ? 25 : 12)) op = OP_ADD_FRONT;
         else if (pick < (grow ? 47 : 22)) op = OP_ADD_END;
         else if (pick < (grow ? 62 : 32)) op = OP_INSERT;
         else if (pick < (grow ? 80 : 55)) op = OP_READ;
         else if (pick < (grow ? 90 : 78)) op = OP_REM_FRONT;
         else op = OP_REM_END;
         if (n > 0 && $urandom_range(0, 4) != 0) pos = POS_W'($urandom_range(0, n - 1));
         else pos = POS_W'($urandom_range(0, 15));
         val = pick_value();
         send_req(op, pos, val, 1'b0, none);
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fails == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : watchdog
      #8_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
